FILE: design/phh_pkg.sv
package phh_pkg;

    localparam int ENERGY_W   = 24;
    localparam int WIDTH_W    = 20;
    localparam int BIN_IDX_W  = 10;
    localparam int OUT_CNT_W  = 32;

    // divider retires this many quotient bits per cycle
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = ENERGY_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_BIN_WIDTH   = 2'd0;
    localparam logic [1:0] REG_LINE        = 2'd1;
    localparam logic [1:0] REG_WINDOW_HALF = 2'd2;

    localparam logic [WIDTH_W-1:0]  BIN_WIDTH_RST   = 20'd1000;
    localparam logic [ENERGY_W-1:0] LINE_RST        = 24'd662000;
    localparam logic [ENERGY_W-1:0] WINDOW_HALF_RST = 24'd10000;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [ENERGY_W-1:0] energy_ev;
        logic [BIN_IDX_W-1:0] read_bin;
    } phh_in_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] bin_value;
        logic [OUT_CNT_W-1:0] events_total;
        logic [OUT_CNT_W-1:0] hits_total;
        logic [OUT_CNT_W-1:0] peak_total;
        logic [BIN_IDX_W-1:0] bin_index;
        logic                 is_hit;
        logic                 in_range;
        logic                 in_window;
    } phh_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic mem_rd;
        logic peak_inc;
        logic mem_upd;
        logic clr_step;
        logic out_load;
    } phh_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       nonzero;
        logic       clr_last;
    } phh_sts_t;

endpackage

FILE: design/phh_ctrl.sv
module phh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    output logic              res_valid,
    input  logic              res_stall,
    input  phh_pkg::phh_sts_t sts,
    output phh_pkg::phh_ctl_t ctl
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam logic [phh_pkg::DIV_CNT_W-1:0] DIV_LAST =
        phh_pkg::DIV_CNT_W'(phh_pkg::DIV_STEPS - 1);

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [phh_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [phh_pkg::DIV_CNT_W-1:0] div_cnt_next;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic                          res_free;

    assign res_free  = !res_valid_reg || !res_stall;
    assign src_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        ctl          = '0;
        ctl.load     = (state_reg == S_IDLE) && src_valid;
        ctl.eval     = (state_reg == S_EVAL);
        ctl.div_step = (state_reg == S_DIV);
        ctl.mem_rd   = (state_reg == S_RD);
        ctl.peak_inc = (state_reg == S_RD);
        ctl.mem_upd  = (state_reg == S_UPD);
        ctl.clr_step = (state_reg == S_INIT) || (state_reg == S_CLR);
        ctl.out_load = (state_reg == S_FIN) && res_free;
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (src_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                div_cnt_next = '0;
                unique case (sts.cmd)
                    phh_pkg::CMD_RECORD: state_next = sts.nonzero ? S_DIV : S_FIN;
                    phh_pkg::CMD_READ:   state_next = S_RD;
                    phh_pkg::CMD_CLEAR:  state_next = S_CLR;
                    phh_pkg::CMD_NOP:    state_next = S_FIN;
                    default:             state_next = S_FIN;
                endcase
            end
            S_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_RD;
            end
            S_RD:  state_next = S_UPD;
            S_UPD: state_next = S_FIN;
            S_CLR:
            begin
                if (sts.clr_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        if (ctl.out_load)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> (state_reg == S_EVAL))
        else $error("accepted item did not move to evaluation");

    a_rd_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> ($past(state_reg) == S_DIV || $past(state_reg) == S_EVAL))
        else $error("memory read entered from unexpected state");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && res_valid_reg && res_stall) |=> (state_reg == S_FIN))
        else $error("finished item left while previous result still stalled");

endmodule

FILE: design/phh_datapath.sv
module phh_datapath #(
    parameter int NUM_BINS   = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  phh_pkg::phh_in_t                 src_item,
    input  logic [phh_pkg::WIDTH_W-1:0]      bin_width_ev,
    input  logic [phh_pkg::ENERGY_W-1:0]     line_ev,
    input  logic [phh_pkg::ENERGY_W-1:0]     window_half_ev,
    input  phh_pkg::phh_ctl_t                ctl,
    output phh_pkg::phh_sts_t                sts,
    output phh_pkg::phh_out_t                res_item
);

    localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int EXT_W  = (COUNT_BITS > 32) ? COUNT_BITS : 33;
    localparam logic [phh_pkg::ENERGY_W-1:0] LAST_BIN = phh_pkg::ENERGY_W'(NUM_BINS - 1);
    localparam logic [BIN_AW-1:0] LAST_ADDR = BIN_AW'(NUM_BINS - 1);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return ((e >> 32) != '0) ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    phh_pkg::phh_in_t                  item_reg;
    logic [phh_pkg::WIDTH_W-1:0]       div_w_reg;
    logic [phh_pkg::WIDTH_W-1:0]       rem_reg;
    logic [phh_pkg::ENERGY_W-1:0]      dq_reg;       // dividend in, quotient out
    logic                              win_reg;
    logic [COUNT_BITS-1:0]             evt_cnt_reg;
    logic [COUNT_BITS-1:0]             hit_cnt_reg;
    logic [COUNT_BITS-1:0]             peak_cnt_reg;
    logic [COUNT_BITS-1:0]             rdata_reg;
    logic [COUNT_BITS-1:0]             bval_reg;
    logic [BIN_AW-1:0]                 clr_addr_reg;
    phh_pkg::phh_out_t                 out_reg;
    logic [COUNT_BITS-1:0]             mem [NUM_BINS];

    logic                              rec;
    logic                              rd;
    logic                              nz;
    logic                              hit;
    logic                              hit_or_read;
    logic                              in_rng;
    logic [BIN_AW-1:0]                 idx;
    logic [phh_pkg::ENERGY_W-1:0]      diff;
    logic                              win_hit;
    logic [phh_pkg::WIDTH_W-1:0]       rem_step;
    logic [phh_pkg::ENERGY_W-1:0]      dq_step;
    logic                              mem_we;
    logic [BIN_AW-1:0]                 mem_waddr;
    logic [COUNT_BITS-1:0]             mem_wdata;

    assign rec         = (item_reg.cmd == phh_pkg::CMD_RECORD);
    assign rd          = (item_reg.cmd == phh_pkg::CMD_READ);
    assign nz          = (item_reg.energy_ev != '0);
    assign hit         = rec && nz;
    assign hit_or_read = hit || rd;
    assign in_rng      = ({8'd0, dq_reg} < 32'(NUM_BINS));
    assign idx         = dq_reg[BIN_AW-1:0];

    always_comb
    begin
        if (item_reg.energy_ev >= line_ev)
            diff = item_reg.energy_ev - line_ev;
        else
            diff = line_ev - item_reg.energy_ev;
        win_hit = (diff <= window_half_ev);
    end

    // restoring divider, DIV_RADIX_BITS quotient bits per cycle
    always_comb
    begin
        logic [phh_pkg::WIDTH_W:0] t;
        rem_step = rem_reg;
        dq_step  = dq_reg;
        for (int k = 0; k < phh_pkg::DIV_RADIX_BITS; k++)
        begin
            t       = {rem_step, dq_step[phh_pkg::ENERGY_W-1]};
            dq_step = {dq_step[phh_pkg::ENERGY_W-2:0], 1'b0};
            if (t >= {1'b0, div_w_reg})
            begin
                rem_step   = phh_pkg::WIDTH_W'(t - {1'b0, div_w_reg});
                dq_step[0] = 1'b1;
            end
            else
            begin
                rem_step = t[phh_pkg::WIDTH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            item_reg <= src_item;
        if (ctl.eval)
        begin
            div_w_reg <= (bin_width_ev == '0) ? phh_pkg::WIDTH_W'(1) : bin_width_ev;
            rem_reg   <= '0;
            dq_reg    <= rec ? item_reg.energy_ev : phh_pkg::ENERGY_W'(item_reg.read_bin);
            win_reg   <= hit && win_hit;
        end
        if (ctl.div_step)
        begin
            rem_reg <= rem_step;
            dq_reg  <= dq_step;
        end
        if (ctl.mem_upd)
            bval_reg <= in_rng ? (rec ? sat_inc(rdata_reg) : rdata_reg) : '0;
        if (ctl.out_load)
        begin
            out_reg.bin_value    <= (hit_or_read && in_rng) ? clip32(bval_reg) : 32'd0;
            out_reg.events_total <= clip32(evt_cnt_reg);
            out_reg.hits_total   <= clip32(hit_cnt_reg);
            out_reg.peak_total   <= clip32(peak_cnt_reg);
            out_reg.bin_index    <= hit_or_read ? (in_rng ? dq_reg[phh_pkg::BIN_IDX_W-1:0]
                                                          : LAST_BIN[phh_pkg::BIN_IDX_W-1:0])
                                                : '0;
            out_reg.is_hit       <= hit;
            out_reg.in_range     <= hit_or_read && in_rng;
            out_reg.in_window    <= win_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_cnt_reg  <= '0;
            hit_cnt_reg  <= '0;
            peak_cnt_reg <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (ctl.eval)
            begin
                if (item_reg.cmd == phh_pkg::CMD_CLEAR)
                begin
                    evt_cnt_reg  <= '0;
                    hit_cnt_reg  <= '0;
                    peak_cnt_reg <= '0;
                end
                else if (rec)
                begin
                    evt_cnt_reg <= sat_inc(evt_cnt_reg);
                    if (nz)
                        hit_cnt_reg <= sat_inc(hit_cnt_reg);
                end
            end
            if (ctl.peak_inc && win_reg)
                peak_cnt_reg <= sat_inc(peak_cnt_reg);
            if (ctl.clr_step)
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + 1'b1;
        end
    end

    // bin store: one write port (sweep or increment), one registered read
    assign mem_we    = ctl.clr_step || (ctl.mem_upd && rec && in_rng);
    assign mem_waddr = ctl.clr_step ? clr_addr_reg : idx;
    assign mem_wdata = ctl.clr_step ? '0 : sat_inc(rdata_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (ctl.mem_rd && in_rng)
            rdata_reg <= mem[idx];
    end

    always_comb
    begin
        sts          = '0;
        sts.cmd      = item_reg.cmd;
        sts.nonzero  = nz;
        sts.clr_last = (clr_addr_reg == LAST_ADDR);
    end

    assign res_item = out_reg;

    a_hits_le_events: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg <= evt_cnt_reg)
        else $error("hit counter exceeds event counter");

    a_peak_le_hits: assert property (@(posedge clk) disable iff (!rst_n)
        peak_cnt_reg <= hit_cnt_reg)
        else $error("photopeak counter exceeds hit counter");

endmodule

FILE: design/pulse_height_histogram.sv
// Pulse-height histogram. Each item carries a command: record counts an event and, for a
// nonzero energy, a hit; the bin energy/bin_width is incremented when below NUM_BINS and a
// photopeak hit is counted when |energy - line| <= window half width. Read returns one bin,
// clear zeroes the counters and every bin. All counts saturate. Exactly one result per item.
// Steps from acceptance to the next acceptance: a record with nonzero energy runs the
// bin-width divider (2 quotient bits per cycle, 12 iterations) followed by a
// read-modify-write of the bin memory; a read skips the divider; a record of zero energy
// and the unused command go straight to the result; clear zeroes the memory one bin per
// cycle. After reset the same sweep zeroes every bin before the first item is taken;
// register writes are accepted throughout. The next item may be taken while the previous
// result waits in the output register; it finishes only once that result has gone.
module pulse_height_histogram #(
    parameter int NUM_BINS   = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  phh_pkg::phh_in_t              src_item,
    output logic                          res_valid,
    input  logic                          res_stall,
    output phh_pkg::phh_out_t             res_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phh_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [phh_pkg::WIDTH_W-1:0]  bin_width_reg;
    logic [phh_pkg::ENERGY_W-1:0] line_reg;
    logic [phh_pkg::ENERGY_W-1:0] window_half_reg;
    logic [1:0]                   reg_sel;
    logic                         reg_wr;
    phh_pkg::phh_ctl_t            ctl;
    phh_pkg::phh_sts_t            sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg   <= phh_pkg::BIN_WIDTH_RST;
            line_reg        <= phh_pkg::LINE_RST;
            window_half_reg <= phh_pkg::WINDOW_HALF_RST;
        end
        else if (reg_wr)
        begin
            unique case (reg_sel)
                phh_pkg::REG_BIN_WIDTH:   bin_width_reg   <= pwdata[phh_pkg::WIDTH_W-1:0];
                phh_pkg::REG_LINE:        line_reg        <= pwdata[phh_pkg::ENERGY_W-1:0];
                phh_pkg::REG_WINDOW_HALF: window_half_reg <= pwdata[phh_pkg::ENERGY_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            phh_pkg::REG_BIN_WIDTH:   prdata = 32'(bin_width_reg);
            phh_pkg::REG_LINE:        prdata = 32'(line_reg);
            phh_pkg::REG_WINDOW_HALF: prdata = 32'(window_half_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    phh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    phh_datapath #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_item       (src_item),
        .bin_width_ev   (bin_width_reg),
        .line_ev        (line_reg),
        .window_half_ev (window_half_reg),
        .ctl            (ctl),
        .sts            (sts),
        .res_item       (res_item)
    );

endmodule

FILE: sim/phh_checker.sv
module phh_checker #(
    parameter int NUM_BINS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    input  logic                        src_stall,
    input  phh_pkg::phh_in_t            src_item,
    input  logic                        res_valid,
    input  logic                        res_stall,
    input  phh_pkg::phh_out_t           res_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [phh_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          pending,
    output int                          results_seen,
    output int                          photopeak_hits,
    output int                          clipped_bins,
    output int                          clears_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [phh_pkg::WIDTH_W-1:0]   bin_width;
    logic [phh_pkg::ENERGY_W-1:0]  line_center;
    logic [phh_pkg::ENERGY_W-1:0]  half_window;
    logic [phh_pkg::OUT_CNT_W-1:0] bin_count [NUM_BINS];
    logic [phh_pkg::OUT_CNT_W-1:0] event_cnt;
    logic [phh_pkg::OUT_CNT_W-1:0] hit_cnt;
    logic [phh_pkg::OUT_CNT_W-1:0] peak_cnt;

    phh_pkg::phh_out_t expected_q[$];
    int err_cnt;
    int result_cnt;
    int peak_seen;
    int clip_seen;
    int clear_cnt;

    function automatic logic [phh_pkg::OUT_CNT_W-1:0] sat_inc(
        input logic [phh_pkg::OUT_CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic clear_histogram();
        bin_count = '{default: '0};
        event_cnt = '0;
        hit_cnt   = '0;
        peak_cnt  = '0;
    endtask

    // Applies one item to the histogram copy and returns the result it should produce.
    task automatic predict_result(input phh_pkg::phh_in_t it, output phh_pkg::phh_out_t r);
        logic [phh_pkg::WIDTH_W-1:0]  divisor;
        logic [phh_pkg::ENERGY_W-1:0] quot;
        logic [phh_pkg::ENERGY_W-1:0] gap;
        r = '0;
        unique case (it.cmd)
            phh_pkg::CMD_RECORD:
            begin
                event_cnt = sat_inc(event_cnt);
                if (it.energy_ev != '0)
                begin
                    divisor = (bin_width == '0) ? phh_pkg::WIDTH_W'(1) : bin_width;
                    quot = it.energy_ev / divisor;
                    gap = (it.energy_ev >= line_center) ? it.energy_ev - line_center
                                                        : line_center - it.energy_ev;
                    r.is_hit = 1'b1;
                    hit_cnt = sat_inc(hit_cnt);
                    if (quot < NUM_BINS)
                    begin
                        r.in_range  = 1'b1;
                        r.bin_index = quot[phh_pkg::BIN_IDX_W-1:0];
                        bin_count[quot[BIN_AW-1:0]] = sat_inc(bin_count[quot[BIN_AW-1:0]]);
                        r.bin_value = bin_count[quot[BIN_AW-1:0]];
                    end
                    else
                    begin
                        r.bin_index = phh_pkg::BIN_IDX_W'(NUM_BINS - 1);
                    end
                    if (gap <= half_window)
                    begin
                        r.in_window = 1'b1;
                        peak_cnt = sat_inc(peak_cnt);
                    end
                end
            end
            phh_pkg::CMD_READ:
            begin
                if (it.read_bin < NUM_BINS)
                begin
                    r.in_range  = 1'b1;
                    r.bin_index = it.read_bin;
                    r.bin_value = bin_count[BIN_AW'(it.read_bin)];
                end
                else
                begin
                    r.bin_index = phh_pkg::BIN_IDX_W'(NUM_BINS - 1);
                end
            end
            phh_pkg::CMD_CLEAR:
            begin
                clear_histogram();
            end
            default:
            begin
            end
        endcase
        r.events_total = event_cnt;
        r.hits_total   = hit_cnt;
        r.peak_total   = peak_cnt;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        phh_pkg::phh_out_t want;
        phh_pkg::phh_out_t fresh;
        if (!rst_n)
        begin
            bin_width   = phh_pkg::BIN_WIDTH_RST;
            line_center = phh_pkg::LINE_RST;
            half_window = phh_pkg::WINDOW_HALF_RST;
            clear_histogram();
            expected_q.delete();
            err_cnt    = 0;
            result_cnt = 0;
            peak_seen  = 0;
            clip_seen  = 0;
            clear_cnt  = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                result_cnt++;
                if (expected_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result with no item outstanding, actual %h", $time, res_item);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("bin_value", want.bin_value, res_item.bin_value);
                    check_field("events_total", want.events_total, res_item.events_total);
                    check_field("hits_total", want.hits_total, res_item.hits_total);
                    check_field("peak_total", want.peak_total, res_item.peak_total);
                    check_field("bin_index", 32'(want.bin_index), 32'(res_item.bin_index));
                    check_field("is_hit", 32'(want.is_hit), 32'(res_item.is_hit));
                    check_field("in_range", 32'(want.in_range), 32'(res_item.in_range));
                    check_field("in_window", 32'(want.in_window), 32'(res_item.in_window));
                end
            end

            if (src_valid && !src_stall)
            begin
                predict_result(src_item, fresh);
                expected_q.push_back(fresh);
                if (fresh.in_window)
                    peak_seen++;
                if (fresh.is_hit && !fresh.in_range)
                    clip_seen++;
                if (src_item.cmd == phh_pkg::CMD_CLEAR)
                    clear_cnt++;
            end

            if (psel && penable && pwrite && pready)
            begin
                unique case (paddr[phh_pkg::PADDR_W-1:2])
                    phh_pkg::REG_BIN_WIDTH:   bin_width   = pwdata[phh_pkg::WIDTH_W-1:0];
                    phh_pkg::REG_LINE:        line_center = pwdata[phh_pkg::ENERGY_W-1:0];
                    phh_pkg::REG_WINDOW_HALF: half_window = pwdata[phh_pkg::ENERGY_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
        mismatches     <= err_cnt;
        pending        <= expected_q.size();
        results_seen   <= result_cnt;
        photopeak_hits <= peak_seen;
        clipped_bins   <= clip_seen;
        clears_seen    <= clear_cnt;
    end

endmodule

FILE: sim/tb_pulse_height_histogram.sv
module tb_pulse_height_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int NUM_BINS      = 1024;
    localparam int LIMIT         = 1_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 255;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         src_valid = 1'b0;
    logic                         src_stall;
    phh_pkg::phh_in_t             src_item  = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    phh_pkg::phh_out_t            res_item;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [phh_pkg::PADDR_W-1:0]  paddr     = '0;
    logic [31:0]                  pwdata    = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    int mismatches;
    int pending;
    int results_seen;
    int photopeak_hits;
    int clipped_bins;
    int clears_seen;

    int src_idle_pct = 0;
    int res_idle_pct = 0;
    int hold_left    = 0;
    int cycle_cnt    = 0;
    int items_sent   = 0;
    int settings_cnt = 1;

    // stimulus-side copy of the registers, used only to aim energies and read bins
    logic [phh_pkg::WIDTH_W-1:0]   cur_bw     = phh_pkg::BIN_WIDTH_RST;
    logic [phh_pkg::ENERGY_W-1:0]  cur_line   = phh_pkg::LINE_RST;
    logic [phh_pkg::ENERGY_W-1:0]  cur_half   = phh_pkg::WINDOW_HALF_RST;
    logic [phh_pkg::BIN_IDX_W-1:0] recent_bin = '0;

    pulse_height_histogram #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    phh_checker #(
        .NUM_BINS (NUM_BINS)
    ) phh_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .src_item       (src_item),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_item       (res_item),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen),
        .photopeak_hits (photopeak_hits),
        .clipped_bins   (clipped_bins),
        .clears_seen    (clears_seen)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding", LIMIT, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // output side: random stall, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                res_stall <= ($urandom_range(0, 99) < res_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [phh_pkg::ENERGY_W-1:0] energy,
                             input logic [phh_pkg::BIN_IDX_W-1:0] rbin);
        phh_pkg::phh_in_t it;
        it.cmd       = cmd;
        it.energy_ev = energy;
        it.read_bin  = rbin;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_item  <= it;
        src_valid <= 1'b1;
        do @(posedge clk); while (src_stall);
        items_sent++;
    endtask

    task automatic wait_idle();
        src_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // psel is dropped after each access to keep back-to-back writes apart
    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [phh_pkg::WIDTH_W-1:0] bw,
                              input logic [phh_pkg::ENERGY_W-1:0] line,
                              input logic [phh_pkg::ENERGY_W-1:0] half);
        apb_write(phh_pkg::REG_BIN_WIDTH, 32'(bw));
        apb_write(phh_pkg::REG_LINE, 32'(line));
        apb_write(phh_pkg::REG_WINDOW_HALF, 32'(half));
        cur_bw   = bw;
        cur_line = line;
        cur_half = half;
        settings_cnt++;
    endtask

    // energies: zero, full scale, around the photopeak, inside the histogram, anywhere
    function automatic logic [phh_pkg::ENERGY_W-1:0] pick_energy();
        longint      span;
        longint      v;
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel < 6)
        begin
            v = longint'(cur_line) - longint'(cur_half) - 2
                + longint'($urandom_range(0, 32'(cur_half) * 2 + 4));
        end
        else if (sel < 12)
        begin
            span = 1024 * longint'((cur_bw == '0) ? phh_pkg::WIDTH_W'(1) : cur_bw);
            v = longint'($urandom_range(0, 32'(span - 1)));
        end
        else
        begin
            v = longint'($urandom_range(0, 24'hFFFFFF));
        end
        if (v < 0)
            v = 0;
        if (v > 24'hFFFFFF)
            v = 24'hFFFFFF;
        return v[phh_pkg::ENERGY_W-1:0];
    endfunction

    task automatic send_random_item();
        int unsigned                   r;
        logic [1:0]                    cmd;
        logic [phh_pkg::ENERGY_W-1:0]  energy;
        logic [phh_pkg::ENERGY_W-1:0]  quot;
        logic [phh_pkg::BIN_IDX_W-1:0] rbin;
        r = $urandom_range(0, 99);
        cmd = (r < 72) ? phh_pkg::CMD_RECORD : (r < 92) ? phh_pkg::CMD_READ :
              (r < 97) ? phh_pkg::CMD_NOP : phh_pkg::CMD_CLEAR;
        energy = (cmd == phh_pkg::CMD_RECORD) ? pick_energy()
                                              : phh_pkg::ENERGY_W'($urandom_range(0, 24'hFFFFFF));
        if (cmd == phh_pkg::CMD_RECORD && energy != '0)
        begin
            quot = energy / ((cur_bw == '0) ? phh_pkg::WIDTH_W'(1) : cur_bw);
            if (quot < NUM_BINS)
                recent_bin = quot[phh_pkg::BIN_IDX_W-1:0];
        end
        // half the reads go back to a bin that was just filled
        if (cmd == phh_pkg::CMD_READ && $urandom_range(0, 1) == 1)
            rbin = recent_bin;
        else
            rbin = phh_pkg::BIN_IDX_W'($urandom_range(0, NUM_BINS - 1));
        send_item(cmd, energy, rbin);
    endtask

    initial
    begin
        int directed_cnt;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 23;
        res_idle_pct = 61;

        // reset registers: 1 keV bins, window 652..672 keV
        send_item(phh_pkg::CMD_RECORD, 24'd0, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd662000, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd652000, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd672000, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd672001, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd1, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd1023999, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd1024000, '0);
        send_item(phh_pkg::CMD_RECORD, 24'hFFFFFF, '0);
        send_item(phh_pkg::CMD_READ, '0, 10'd662);
        send_item(phh_pkg::CMD_READ, '0, 10'd0);
        send_item(phh_pkg::CMD_READ, '0, 10'd1023);
        send_item(phh_pkg::CMD_NOP, 24'hFFFFFF, 10'd1023);
        send_item(phh_pkg::CMD_CLEAR, '0, '0);
        send_item(phh_pkg::CMD_READ, '0, 10'd662);
        send_item(phh_pkg::CMD_RECORD, 24'd662000, '0);

        // zero bin width behaves as one eV
        wait_idle();
        set_config('0, '0, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd1, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd1023, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd1024, '0);
        send_item(phh_pkg::CMD_READ, '0, 10'd1023);
        send_item(phh_pkg::CMD_RECORD, 24'd0, '0);

        wait_idle();
        set_config('1, '1, '1);
        send_item(phh_pkg::CMD_RECORD, 24'hFFFFFF, '0);
        send_item(phh_pkg::CMD_RECORD, 24'd1, '0);
        send_item(phh_pkg::CMD_READ, '0, 10'd16);
        send_item(phh_pkg::CMD_READ, '0, 10'd1023);
        directed_cnt = items_sent;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            unique case (phase)
                0: set_config(20'd1, 24'($urandom_range(0, 1023)), 24'($urandom_range(0, 64)));
                1: set_config(20'd1000000, 24'hFFFFFF, 24'($urandom_range(0, 2000000)));
                2: set_config(20'($urandom_range(1000, 16384)), 24'($urandom_range(0, 24'hFFFFFF)),
                              24'($urandom_range(0, 50000)));
                3: set_config(20'($urandom_range(2, 200)), 24'($urandom_range(0, 204800)),
                              24'($urandom_range(0, 5000)));
                4: set_config(20'd16384, phh_pkg::LINE_RST, phh_pkg::WINDOW_HALF_RST);
                default: set_config(20'($urandom_range(1, 20'hFFFFF)),
                                    24'($urandom_range(0, 24'hFFFFFF)),
                                    24'($urandom_range(0, 24'hFFFFFF)));
            endcase
            unique case (phase / 2)
                0:
                begin
                    src_idle_pct = 23;
                    res_idle_pct = 61;
                end
                1:
                begin
                    src_idle_pct = 61;
                    res_idle_pct = 23;
                end
                default:
                begin
                    src_idle_pct = 0;
                    res_idle_pct = 0;
                end
            endcase
            // output held off while items keep coming, so the input backs up
            if (phase == 4)
                hold_left = HOLD_CYCLES;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random_item();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items (%0d directed) under %0d register settings, %0d results checked",
                 items_sent, directed_cnt, settings_cnt, results_seen);
        $display("Photopeak hits %0d, hits past the last bin %0d, clears %0d, mismatches %0d",
                 photopeak_hits, clipped_bins, clears_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
